FILE: rtl/core/stt_pkg.sv
// Shared types and constants for the scene text tokenizer.
// Used by scene_text_tokenizer_unit; no dependencies.
package stt_pkg;

  localparam int unsigned LenW = 11;

  typedef enum logic [4:0] {
    MODE_IDLE    = 5'b00001,
    MODE_QUOTED  = 5'b00010,
    MODE_ESCAPE  = 5'b00100,
    MODE_BRACKET = 5'b01000,
    MODE_WORD    = 5'b10000
  } stt_mode_t;

  typedef enum logic [1:0] {
    KIND_SINGLE  = 2'd0,
    KIND_QUOTED  = 2'd1,
    KIND_BRACKET = 2'd2,
    KIND_WORD    = 2'd3
  } stt_kind_t;

  localparam logic [7:0] CH_LBRACE    = 8'h7B;
  localparam logic [7:0] CH_RBRACE    = 8'h7D;
  localparam logic [7:0] CH_LPAREN    = 8'h28;
  localparam logic [7:0] CH_RPAREN    = 8'h29;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_BACKSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACKET  = 8'h5B;
  localparam logic [7:0] CH_RBRACKET  = 8'h5D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_CR        = 8'h0D;

  localparam logic [LenW-1:0] MAX_LEN_RESET = 11'd256;

  // register index as decoded from paddr
  localparam logic REG_MAX_LEN = 1'b0;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } stt_in_t;

  typedef struct packed {
    logic [7:0]      out_byte;
    logic            has_byte;
    logic            last_of_token;
    logic [1:0]      token_kind;
    logic [LenW-1:0] token_length;
    logic            truncated;
  } stt_out_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

endpackage

FILE: rtl/core/scene_text_tokenizer_unit.sv
// Scene text tokenizer: one byte in per transfer, at most one token byte out.
// The result of an accepted input, if any, is written straight into the output register.
// Throughput: 1 byte per cycle while in_stall is low; the mode/count next state is combinational.
// The input stalls only while the output register is full and stalled.
// Reset (rst_n, synchronous, active low): idle between tokens, count and
// truncation flag cleared, output empty, max_token_length = 256.
module scene_text_tokenizer_unit
  import stt_pkg::*;
#(
  parameter int unsigned TOKEN_LIMIT = 1024
) (
  input  logic          clk,
  input  logic          rst_n,

  input  logic          in_valid,
  output logic          in_stall,
  input  stt_in_t       in_data,

  output logic          out_valid,
  input  logic          out_stall,
  output stt_out_t      out_data,

  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  // limit clamp: the register cannot exceed 2047, so cap the parameter there
  localparam int unsigned LimCap = (TOKEN_LIMIT > 2047) ? 2047 : TOKEN_LIMIT;
  localparam logic [LenW-1:0] LIM_PARAM = LimCap[LenW-1:0];

  logic [LenW-1:0] max_len_r;
  stt_mode_t       mode_r, mode_nxt;
  logic [LenW-1:0] cnt_r, cnt_nxt;
  logic            drop_r, drop_nxt;
  logic            out_valid_r;
  stt_out_t        out_r;

  logic            acc;
  logic            res_valid;
  stt_out_t        res;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_MAX_LEN);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_MAX_LEN) prdata = {{(32-LenW){1'b0}}, max_len_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr) begin
      max_len_r <= pwdata[LenW-1:0];
    end
  end

  assign in_stall = out_valid_r && out_stall;
  assign acc      = in_valid && !in_stall;

  // token step
  logic [LenW-1:0] lim, eff_cnt, cnt_k;
  logic            eff_drop, drop_k, keep, idle, blank;
  logic [7:0]      c;
  logic [1:0]      cur_kind;

  always_comb begin
    lim      = (max_len_r > LIM_PARAM) ? LIM_PARAM : max_len_r;
    idle     = (mode_r != MODE_QUOTED) && (mode_r != MODE_ESCAPE) &&
               (mode_r != MODE_BRACKET) && (mode_r != MODE_WORD);
    eff_cnt  = idle ? '0 : cnt_r;
    eff_drop = idle ? 1'b0 : drop_r;
    keep     = eff_cnt < lim;
    cnt_k    = keep ? eff_cnt + 1'b1 : eff_cnt;
    drop_k   = eff_drop | ~keep;
    c        = in_data.in_byte;
    blank    = is_blank(c);
    if (mode_r == MODE_QUOTED || mode_r == MODE_ESCAPE) cur_kind = KIND_QUOTED;
    else if (mode_r == MODE_BRACKET)                     cur_kind = KIND_BRACKET;
    else                                                  cur_kind = KIND_WORD;

    res_valid = 1'b0;
    res       = '0;
    mode_nxt  = idle ? MODE_IDLE : mode_r;
    cnt_nxt   = eff_cnt;
    drop_nxt  = eff_drop;

    if (in_data.end_of_input) begin
      if (!idle) begin
        res_valid          = 1'b1;
        res.last_of_token  = 1'b1;
        res.token_kind     = cur_kind;
        res.token_length   = cnt_r;
        res.truncated      = drop_r;
      end
    end else begin
      unique case (mode_r)
        MODE_QUOTED: begin
          if (c == CH_QUOTE) begin
            res_valid         = 1'b1;
            res.last_of_token = 1'b1;
            res.token_kind    = KIND_QUOTED;
            res.token_length  = cnt_r;
            res.truncated     = drop_r;
          end else if (c == CH_BACKSLASH) begin
            mode_nxt = MODE_ESCAPE;
          end else begin
            res_valid = keep;
            cnt_nxt   = cnt_k;
            drop_nxt  = drop_k;
            res.token_kind = KIND_QUOTED;
          end
        end
        MODE_ESCAPE: begin
          mode_nxt  = MODE_QUOTED;
          res_valid = keep;
          cnt_nxt   = cnt_k;
          drop_nxt  = drop_k;
          res.token_kind = KIND_QUOTED;
        end
        MODE_BRACKET: begin
          res.token_kind = KIND_BRACKET;
          cnt_nxt        = cnt_k;
          drop_nxt       = drop_k;
          if (c == CH_RBRACKET) begin
            res_valid         = 1'b1;
            res.last_of_token = 1'b1;
          end else begin
            res_valid = keep;
          end
        end
        MODE_WORD: begin
          res.token_kind = KIND_WORD;
          if (blank) begin
            res_valid         = 1'b1;
            res.last_of_token = 1'b1;
            res.token_length  = cnt_r;
            res.truncated     = drop_r;
          end else begin
            res_valid = keep;
            cnt_nxt   = cnt_k;
            drop_nxt  = drop_k;
          end
        end
        default: begin
          // idle, or an illegal code, which recovers as idle
          if (blank) begin
            mode_nxt = MODE_IDLE;
          end else if (c == CH_LBRACE || c == CH_RBRACE ||
                       c == CH_LPAREN || c == CH_RPAREN) begin
            res_valid         = 1'b1;
            res.last_of_token = 1'b1;
            res.token_kind    = KIND_SINGLE;
            cnt_nxt           = cnt_k;
            drop_nxt          = drop_k;
          end else if (c == CH_QUOTE) begin
            mode_nxt = MODE_QUOTED;
          end else begin
            mode_nxt       = (c == CH_LBRACKET) ? MODE_BRACKET : MODE_WORD;
            res.token_kind = (c == CH_LBRACKET) ? KIND_BRACKET : KIND_WORD;
            res_valid      = keep;
            cnt_nxt        = cnt_k;
            drop_nxt       = drop_k;
          end
        end
      endcase

      // a result that stores the byte carries it with the updated count
      if (res_valid && !(res.last_of_token && res.token_length == '0 &&
                         (mode_r == MODE_QUOTED || mode_r == MODE_WORD))) begin
        res.has_byte     = keep;
        res.out_byte     = keep ? c : 8'h00;
        res.token_length = cnt_k;
        res.truncated    = drop_k;
      end
    end

    if (res_valid && res.last_of_token) begin
      mode_nxt = MODE_IDLE;
      cnt_nxt  = '0;
      drop_nxt = 1'b0;
    end
  end

  // Closing results without a byte (closing quote, blank after word) are
  // flagged separately so res_fix restores their fields after the byte path above.
  logic close_nobyte;
  assign close_nobyte = !in_data.end_of_input &&
                        ((mode_r == MODE_QUOTED && c == CH_QUOTE) ||
                         (mode_r == MODE_WORD && blank));

  stt_out_t res_fix;
  always_comb begin
    res_fix = res;
    if (close_nobyte) begin
      res_fix.has_byte     = 1'b0;
      res_fix.out_byte     = 8'h00;
      res_fix.token_length = cnt_r;
      res_fix.truncated    = drop_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_IDLE;
      cnt_r       <= '0;
      drop_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (acc) begin
        mode_r      <= mode_nxt;
        cnt_r       <= cnt_nxt;
        drop_r      <= drop_nxt;
        out_valid_r <= res_valid;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc && res_valid) out_r <= res_fix;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid_r)
    else $error("input stalled with empty output register");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_IDLE) |-> (cnt_r == '0 && !drop_r))
    else $error("idle with nonzero count or truncation flag");

  a_close_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && res_valid && res_fix.last_of_token) |=> (mode_r == MODE_IDLE))
    else $error("token closed but mode not idle");

  a_nobyte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.has_byte) |-> (out_r.out_byte == 8'h00))
    else $error("result without byte carries nonzero out_byte");

  a_single_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.token_kind == KIND_SINGLE) |->
      (out_r.last_of_token && out_r.token_length <= 11'd1))
    else $error("single-byte token malformed");

endmodule
